// ----- rtl/page_span_allocator_top_macros.svh -----
// Assertion macros shared by the page span allocator RTL.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef PAGE_SPAN_ALLOCATOR_TOP_MACROS_SVH
`define PAGE_SPAN_ALLOCATOR_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PSA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/psa_pkg.sv -----
// Constants and codes of the page span allocator.
// No dependencies; used by page_span_allocator_top.
package psa_pkg;

  localparam int DEF_POOL_PAGES     = 4096;
  localparam int DEF_MAX_SPAN_PAGES = 128;
  localparam int DEF_PAGE_BITS      = 13;

  localparam int KIND_W   = 2;
  localparam int PAGES_W  = 8;
  localparam int FIRST_W  = 12;
  localparam int ADDR_W   = 25;
  localparam int STATUS_W = 2;
  localparam int LEN_W    = 8;
  localparam int SUM_W    = 9;

  localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LOOKUP  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOMEM  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOSPAN = 2'd3;

endpackage

// ----- rtl/page_span_allocator_top.sv -----
// Page span allocator: free lists per span length, page map and span records in memories.
// Depends on psa_pkg and page_span_allocator_top_macros.svh.
//
//   channel | direction | words
//   in_*    | input     | kind, pages, first_page, address
//   out_*   | output    | status, span_first, span_pages
//
// After reset all POOL_PAGES page map entries are cleared, one entry a cycle, with in_ready low.
// In an allocate, the list scan checks one length a cycle (up to MAX_SPAN_PAGES),
// and the page map is written one page a cycle.
// One item is worked at a time; a finished word waits in the output register.
module page_span_allocator_top #(
  parameter int POOL_PAGES     = psa_pkg::DEF_POOL_PAGES,
  parameter int MAX_SPAN_PAGES = psa_pkg::DEF_MAX_SPAN_PAGES,
  parameter int PAGE_BITS      = psa_pkg::DEF_PAGE_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [psa_pkg::KIND_W-1:0]     in_kind,
  input  logic [psa_pkg::PAGES_W-1:0]    in_pages,
  input  logic [psa_pkg::FIRST_W-1:0]    in_first_page,
  input  logic [psa_pkg::ADDR_W-1:0]     in_address,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [psa_pkg::STATUS_W-1:0]   out_status,
  output logic [psa_pkg::FIRST_W-1:0]    out_span_first,
  output logic [psa_pkg::PAGES_W-1:0]    out_span_pages
);
  import psa_pkg::*;

  localparam int IW = $clog2(POOL_PAGES);
  localparam int PW = IW + 1;
  localparam int SW = $clog2(MAX_SPAN_PAGES);
  localparam logic [PW-1:0] NIL = PW'(POOL_PAGES);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_FIN,
    A_SCAN, A_HEAD, A_SPLIT, A_ROWN1, A_ROWN2, A_MARK,
    R_CHK0, R_CHK1, R_BACK0, R_BACK1, R_BACK2, R_FWD0, R_FWD1, R_FWD2,
    R_PUSH, R_OWN1, R_OWN2,
    L_0, L_1, L_2,
    RM_0, RM_1, RM_2, RM_3,
    PU_0, PU_1, PU_2
  } state_t;

  logic [PW-1:0] own_mem  [POOL_PAGES];
  logic [LEN_W-1:0] len_mem [POOL_PAGES];
  logic          busy_mem [POOL_PAGES];
  logic [PW-1:0] nxt_mem  [POOL_PAGES];
  logic [PW-1:0] prv_mem  [POOL_PAGES];
  logic [PW-1:0] head_mem [MAX_SPAN_PAGES];

  state_t state_r, state_nxt, ret_r, ret_nxt;
  logic [IW-1:0] clr_r, clr_nxt;
  logic [MAX_SPAN_PAGES-1:0] ne_r, ne_nxt;
  logic [PW-1:0] refill_r, refill_nxt;
  logic [SW-1:0] scan_r, scan_nxt;
  logic [SUM_W-1:0] k_r, k_nxt, n_r, n_nxt, i_r, i_nxt;
  logic [PW-1:0] s_r, s_nxt, o_r, o_nxt, p_r, p_nxt;
  logic [PW-1:0] rm_s_r, rm_s_nxt, rm_nx_r, rm_nx_nxt, rm_pv_r, rm_pv_nxt;
  logic [SUM_W-1:0] rm_len_r, rm_len_nxt;
  logic [PW-1:0] pu_s_r, pu_s_nxt, pu_h_r, pu_h_nxt;
  logic [SUM_W-1:0] pu_len_r, pu_len_nxt;
  logic [STATUS_W-1:0] res_st_r, res_st_nxt;
  logic [PW-1:0] res_first_r, res_first_nxt;
  logic [SUM_W-1:0] res_pages_r, res_pages_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [FIRST_W-1:0] out_first_r, out_first_nxt;
  logic [PAGES_W-1:0] out_pages_r, out_pages_nxt;

  logic [IW-1:0] own_ra, rec_ra, own_wa, len_wa, busy_wa, nxt_wa, prv_wa;
  logic [SW-1:0] head_ra, head_wa;
  logic own_we, len_we, busy_we, nxt_we, prv_we, head_we;
  logic [PW-1:0] own_wd, nxt_wd, prv_wd, head_wd;
  logic [LEN_W-1:0] len_wd;
  logic busy_wd;
  logic [PW-1:0] own_q, nxt_q, prv_q, head_q;
  logic [LEN_W-1:0] len_q;
  logic busy_q;

  logic [ADDR_W-1:0] lk_page;
  logic [31:0] sum_sn, sum_ol;
  logic [SUM_W-1:0] ol;
  logic acc_known;

  always_ff @(posedge clk) begin
    own_q <= own_mem[own_ra];
    if (own_we) begin
      own_mem[own_wa] <= own_wd;
    end
  end

  always_ff @(posedge clk) begin
    len_q  <= len_mem[rec_ra];
    busy_q <= busy_mem[rec_ra];
    nxt_q  <= nxt_mem[rec_ra];
    prv_q  <= prv_mem[rec_ra];
    if (len_we) begin
      len_mem[len_wa] <= len_wd;
    end
    if (busy_we) begin
      busy_mem[busy_wa] <= busy_wd;
    end
    if (nxt_we) begin
      nxt_mem[nxt_wa] <= nxt_wd;
    end
    if (prv_we) begin
      prv_mem[prv_wa] <= prv_wd;
    end
  end

  always_ff @(posedge clk) begin
    head_q <= head_mem[head_ra];
    if (head_we) begin
      head_mem[head_wa] <= head_wd;
    end
  end

  assign lk_page = in_address >> PAGE_BITS;
  assign sum_sn  = 32'(s_r) + 32'(n_r);
  assign ol      = SUM_W'(len_q);
  assign sum_ol  = 32'(ol) + 32'(n_r);

  always_comb begin
    state_nxt = state_r;
    ret_nxt = ret_r;
    clr_nxt = clr_r;
    ne_nxt = ne_r;
    refill_nxt = refill_r;
    scan_nxt = scan_r;
    k_nxt = k_r;
    n_nxt = n_r;
    i_nxt = i_r;
    s_nxt = s_r;
    o_nxt = o_r;
    p_nxt = p_r;
    rm_s_nxt = rm_s_r;
    rm_nx_nxt = rm_nx_r;
    rm_pv_nxt = rm_pv_r;
    rm_len_nxt = rm_len_r;
    pu_s_nxt = pu_s_r;
    pu_h_nxt = pu_h_r;
    pu_len_nxt = pu_len_r;
    res_st_nxt = res_st_r;
    res_first_nxt = res_first_r;
    res_pages_nxt = res_pages_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_first_nxt = out_first_r;
    out_pages_nxt = out_pages_r;
    own_ra = IW'(0);
    rec_ra = IW'(0);
    head_ra = SW'(0);
    own_we = 1'b0;
    own_wa = IW'(0);
    own_wd = NIL;
    len_we = 1'b0;
    len_wa = IW'(0);
    len_wd = LEN_W'(0);
    busy_we = 1'b0;
    busy_wa = IW'(0);
    busy_wd = 1'b0;
    nxt_we = 1'b0;
    nxt_wa = IW'(0);
    nxt_wd = NIL;
    prv_we = 1'b0;
    prv_wa = IW'(0);
    prv_wd = NIL;
    head_we = 1'b0;
    head_wa = SW'(0);
    head_wd = NIL;

    unique case (state_r)
      S_CLEAR: begin
        own_we = 1'b1;
        own_wa = clr_r;
        own_wd = NIL;
        clr_nxt = clr_r + IW'(1);
        if (clr_r == IW'(POOL_PAGES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        res_first_nxt = PW'(0);
        res_pages_nxt = SUM_W'(0);
        if (in_valid) begin
          case (in_kind)
            KIND_ALLOC: begin
              k_nxt = SUM_W'(in_pages);
              if (in_pages == PAGES_W'(0) || 32'(in_pages) > MAX_SPAN_PAGES) begin
                res_st_nxt = ST_RANGE;
                state_nxt = S_FIN;
              end else begin
                scan_nxt = SW'(in_pages - PAGES_W'(1));
                state_nxt = A_SCAN;
              end
            end
            KIND_RELEASE: begin
              if (in_pages == PAGES_W'(0) || 32'(in_pages) > MAX_SPAN_PAGES) begin
                res_st_nxt = ST_RANGE;
                state_nxt = S_FIN;
              end else if (32'(in_first_page) >= POOL_PAGES) begin
                res_st_nxt = ST_NOSPAN;
                state_nxt = S_FIN;
              end else begin
                s_nxt = PW'(in_first_page);
                n_nxt = SUM_W'(in_pages);
                state_nxt = R_CHK0;
              end
            end
            KIND_LOOKUP: begin
              if (32'(lk_page) >= POOL_PAGES) begin
                res_st_nxt = ST_NOSPAN;
                state_nxt = S_FIN;
              end else begin
                p_nxt = PW'(lk_page);
                state_nxt = L_0;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_status_nxt = res_st_r;
          out_first_nxt = FIRST_W'(res_first_r);
          out_pages_nxt = PAGES_W'(res_pages_r);
          state_nxt = S_IDLE;
        end
      end
      A_SCAN: begin
        head_ra = scan_r;
        if (ne_r[scan_r]) begin
          state_nxt = A_HEAD;
        end else if (scan_r == SW'(MAX_SPAN_PAGES - 1)) begin
          if (32'(POOL_PAGES) - 32'(refill_r) < 32'(MAX_SPAN_PAGES)) begin
            res_st_nxt = ST_NOMEM;
            state_nxt = S_FIN;
          end else begin
            s_nxt = refill_r;
            refill_nxt = PW'(32'(refill_r) + 32'(MAX_SPAN_PAGES));
            n_nxt = SUM_W'(MAX_SPAN_PAGES);
            nxt_we = 1'b1;
            nxt_wa = IW'(refill_r);
            nxt_wd = NIL;
            prv_we = 1'b1;
            prv_wa = IW'(refill_r);
            prv_wd = NIL;
            state_nxt = A_SPLIT;
          end
        end else begin
          scan_nxt = scan_r + SW'(1);
        end
      end
      A_HEAD: begin
        s_nxt = head_q;
        n_nxt = SUM_W'(scan_r) + SUM_W'(1);
        rm_s_nxt = head_q;
        ret_nxt = A_SPLIT;
        state_nxt = RM_0;
      end
      A_SPLIT: begin
        i_nxt = SUM_W'(0);
        if (n_r > k_r) begin
          pu_s_nxt = PW'(32'(s_r) + 32'(k_r));
          pu_len_nxt = n_r - k_r;
          ret_nxt = A_ROWN1;
          state_nxt = PU_0;
        end else begin
          state_nxt = A_MARK;
        end
      end
      A_ROWN1: begin
        own_we = 1'b1;
        own_wa = IW'(32'(s_r) + 32'(k_r));
        own_wd = PW'(32'(s_r) + 32'(k_r));
        state_nxt = A_ROWN2;
      end
      A_ROWN2: begin
        own_we = 1'b1;
        own_wa = IW'(sum_sn - 32'd1);
        own_wd = PW'(32'(s_r) + 32'(k_r));
        state_nxt = A_MARK;
      end
      A_MARK: begin
        len_we = 1'b1;
        len_wa = IW'(s_r);
        len_wd = LEN_W'(k_r);
        busy_we = 1'b1;
        busy_wa = IW'(s_r);
        busy_wd = 1'b1;
        own_we = 1'b1;
        own_wa = IW'(32'(s_r) + 32'(i_r));
        own_wd = s_r;
        i_nxt = i_r + SUM_W'(1);
        if (i_r == k_r - SUM_W'(1)) begin
          res_st_nxt = ST_OK;
          res_first_nxt = s_r;
          res_pages_nxt = k_r;
          state_nxt = S_FIN;
        end
      end
      R_CHK0: begin
        own_ra = IW'(s_r);
        rec_ra = IW'(s_r);
        state_nxt = R_CHK1;
      end
      R_CHK1: begin
        if (own_q != s_r || !busy_q || ol != n_r) begin
          res_st_nxt = ST_NOSPAN;
          state_nxt = S_FIN;
        end else begin
          state_nxt = R_BACK0;
        end
      end
      R_BACK0: begin
        own_ra = IW'(s_r - PW'(1));
        state_nxt = (s_r == PW'(0)) ? R_FWD0 : R_BACK1;
      end
      R_BACK1: begin
        o_nxt = own_q;
        rec_ra = IW'(own_q);
        state_nxt = (own_q >= NIL) ? R_FWD0 : R_BACK2;
      end
      R_BACK2: begin
        if (ol == SUM_W'(0) || 32'(o_r) + 32'(ol) != 32'(s_r) || busy_q ||
            sum_ol > 32'(MAX_SPAN_PAGES)) begin
          state_nxt = R_FWD0;
        end else begin
          rm_s_nxt = o_r;
          s_nxt = o_r;
          n_nxt = SUM_W'(sum_ol);
          ret_nxt = R_BACK0;
          state_nxt = RM_0;
        end
      end
      R_FWD0: begin
        own_ra = IW'(sum_sn);
        state_nxt = (sum_sn >= 32'(POOL_PAGES)) ? R_PUSH : R_FWD1;
      end
      R_FWD1: begin
        o_nxt = own_q;
        rec_ra = IW'(own_q);
        state_nxt = (32'(own_q) != sum_sn) ? R_PUSH : R_FWD2;
      end
      R_FWD2: begin
        if (busy_q || ol == SUM_W'(0) || sum_ol > 32'(MAX_SPAN_PAGES)) begin
          state_nxt = R_PUSH;
        end else begin
          rm_s_nxt = o_r;
          n_nxt = SUM_W'(sum_ol);
          ret_nxt = R_FWD0;
          state_nxt = RM_0;
        end
      end
      R_PUSH: begin
        pu_s_nxt = s_r;
        pu_len_nxt = n_r;
        ret_nxt = R_OWN1;
        state_nxt = PU_0;
      end
      R_OWN1: begin
        own_we = 1'b1;
        own_wa = IW'(s_r);
        own_wd = s_r;
        state_nxt = R_OWN2;
      end
      R_OWN2: begin
        own_we = 1'b1;
        own_wa = IW'(sum_sn - 32'd1);
        own_wd = s_r;
        res_st_nxt = ST_OK;
        res_first_nxt = s_r;
        res_pages_nxt = n_r;
        state_nxt = S_FIN;
      end
      L_0: begin
        own_ra = IW'(p_r);
        state_nxt = L_1;
      end
      L_1: begin
        o_nxt = own_q;
        rec_ra = IW'(own_q);
        if (own_q >= NIL) begin
          res_st_nxt = ST_NOSPAN;
          state_nxt = S_FIN;
        end else begin
          state_nxt = L_2;
        end
      end
      L_2: begin
        if (ol == SUM_W'(0) || o_r > p_r || 32'(p_r) >= 32'(o_r) + 32'(ol)) begin
          res_st_nxt = ST_NOSPAN;
        end else begin
          res_st_nxt = ST_OK;
          res_first_nxt = o_r;
          res_pages_nxt = ol;
        end
        state_nxt = S_FIN;
      end
      RM_0: begin
        rec_ra = IW'(rm_s_r);
        state_nxt = RM_1;
      end
      RM_1: begin
        rm_len_nxt = ol;
        rm_nx_nxt = nxt_q;
        rm_pv_nxt = prv_q;
        head_ra = SW'(ol - SUM_W'(1));
        if (ol == SUM_W'(0) || 32'(ol) > MAX_SPAN_PAGES) begin
          state_nxt = ret_r;
        end else begin
          state_nxt = RM_2;
        end
      end
      RM_2: begin
        if (rm_pv_r < NIL) begin
          nxt_we = 1'b1;
          nxt_wa = IW'(rm_pv_r);
          nxt_wd = rm_nx_r;
        end else if (ne_r[SW'(rm_len_r - SUM_W'(1))] && head_q == rm_s_r) begin
          head_we = 1'b1;
          head_wa = SW'(rm_len_r - SUM_W'(1));
          head_wd = rm_nx_r;
        end
        if (rm_nx_r < NIL) begin
          prv_we = 1'b1;
          prv_wa = IW'(rm_nx_r);
          prv_wd = rm_pv_r;
        end
        state_nxt = RM_3;
      end
      RM_3: begin
        nxt_we = 1'b1;
        nxt_wa = IW'(rm_s_r);
        nxt_wd = NIL;
        prv_we = 1'b1;
        prv_wa = IW'(rm_s_r);
        prv_wd = NIL;
        state_nxt = ret_r;
      end
      PU_0: begin
        head_ra = SW'(pu_len_r - SUM_W'(1));
        state_nxt = PU_1;
      end
      PU_1: begin
        pu_h_nxt = ne_r[SW'(pu_len_r - SUM_W'(1))] ? head_q : NIL;
        len_we = 1'b1;
        len_wa = IW'(pu_s_r);
        len_wd = LEN_W'(pu_len_r);
        busy_we = 1'b1;
        busy_wa = IW'(pu_s_r);
        busy_wd = 1'b0;
        prv_we = 1'b1;
        prv_wa = IW'(pu_s_r);
        prv_wd = NIL;
        nxt_we = 1'b1;
        nxt_wa = IW'(pu_s_r);
        nxt_wd = ne_r[SW'(pu_len_r - SUM_W'(1))] ? head_q : NIL;
        head_we = 1'b1;
        head_wa = SW'(pu_len_r - SUM_W'(1));
        head_wd = pu_s_r;
        state_nxt = PU_2;
      end
      PU_2: begin
        if (pu_h_r < NIL) begin
          prv_we = 1'b1;
          prv_wa = IW'(pu_h_r);
          prv_wd = pu_s_r;
        end
        state_nxt = ret_r;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (head_we) begin
      ne_nxt[head_wa] = head_wd < NIL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      ret_r <= S_IDLE;
      clr_r <= '0;
      ne_r <= '0;
      refill_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ret_r <= ret_nxt;
      clr_r <= clr_nxt;
      ne_r <= ne_nxt;
      refill_r <= refill_nxt;
      out_valid_r <= out_valid_nxt;
    end
    scan_r <= scan_nxt;
    k_r <= k_nxt;
    n_r <= n_nxt;
    i_r <= i_nxt;
    s_r <= s_nxt;
    o_r <= o_nxt;
    p_r <= p_nxt;
    rm_s_r <= rm_s_nxt;
    rm_nx_r <= rm_nx_nxt;
    rm_pv_r <= rm_pv_nxt;
    rm_len_r <= rm_len_nxt;
    pu_s_r <= pu_s_nxt;
    pu_h_r <= pu_h_nxt;
    pu_len_r <= pu_len_nxt;
    res_st_r <= res_st_nxt;
    res_first_r <= res_first_nxt;
    res_pages_r <= res_pages_nxt;
    out_status_r <= out_status_nxt;
    out_first_r <= out_first_nxt;
    out_pages_r <= out_pages_nxt;
  end

  assign in_ready       = (state_r == S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_span_first = out_first_r;
  assign out_span_pages = out_pages_r;

  assign acc_known = in_valid && in_ready &&
                     (in_kind == KIND_ALLOC || in_kind == KIND_RELEASE ||
                      in_kind == KIND_LOOKUP);

`include "page_span_allocator_top_macros.svh"

  `PSA_ASSERT_NEXT(a_one_word_at_a_time, acc_known, !in_ready, "accepted two words back to back")
  `PSA_ASSERT_NOW(a_refill_in_pool, 1'b1, 32'(refill_r) <= 32'(POOL_PAGES), "refill pointer beyond pool")
  `PSA_ASSERT_NOW(a_ok_has_pages, out_valid && out_status == ST_OK, out_span_pages != '0, "ok word with zero pages")
  `PSA_ASSERT_NEXT(a_fin_loads_out, state_r == S_FIN && (!out_valid_r || out_ready), out_valid && state_r == S_IDLE, "finished word not presented")

endmodule
